[rtl/dthe_pkg.sv]
// Package for the DER tag/length header encoder.
// Descriptor and header record types, status codes and sizing constants.
// No dependencies.
`default_nettype none

package dthe_pkg;

  localparam int unsigned HDR_MAX   = 11;
  localparam int unsigned TAG_GRP   = 5;
  localparam int unsigned LEN_BYTES = 4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DEFAULT  = 3'd1;
  localparam logic [2:0] ST_ABSENT   = 3'd2;
  localparam logic [2:0] ST_TAG_BAD  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;
  localparam logic [2:0] ST_BAD_RULE = 3'd5;

  localparam logic [4:0] LONG_TAG_MARK = 5'h1f;
  localparam logic [7:0] LEN_LONG_BASE = 8'h80;

  typedef struct packed {
    logic [31:0] tag_number;
    logic [2:0]  class_bits;
    logic [31:0] content_length;
    logic        is_present;
    logic        is_dummy;
    logic        is_default_value;
  } desc_t;

  typedef struct packed {
    logic [HDR_MAX-1:0][7:0] bytes;
    logic [3:0]              count;
    logic [3:0]              header_size;
    logic [2:0]              status;
    logic                    byte_valid;
  } hdr_t;

endpackage

`default_nettype wire

[rtl/dthe_build.sv]
// Header builder: turns one registered descriptor into its DER header bytes.
// Pure combinational; uses dthe_pkg types and codes.
`default_nettype none

module dthe_build
  import dthe_pkg::*;
(
  input  wire desc_t rule_desc,
  input  wire logic  rule_is_der,
  output hdr_t       hdr
);

  logic [TAG_GRP:0][7:0]    tb;
  logic [LEN_BYTES:0][7:0]  lb;
  logic [2:0]               groups;
  logic [2:0]               nb;
  logic [3:0]               tn;
  logic [3:0]               ln;
  logic [3:0]               n;
  logic [4:0]               tsh;
  logic [4:0]               lsh;
  logic [3:0]               rel;
  logic [31:0]              tag;
  logic [31:0]              len;

  assign tag = rule_desc.tag_number;
  assign len = rule_desc.content_length;

  always_comb begin
    tb     = '0;
    groups = 3'd1;
    tsh    = '0;
    if (tag < 32'(LONG_TAG_MARK)) begin
      tb[0] = {rule_desc.class_bits, tag[4:0]};
      tn    = 4'd1;
    end else begin
      tb[0] = {rule_desc.class_bits, LONG_TAG_MARK};
      if (tag > 32'h7f)      groups = 3'd2;
      if (tag > 32'h3fff)    groups = 3'd3;
      if (tag > 32'h1fffff)  groups = 3'd4;
      if (tag > 32'hfffffff) groups = 3'd5;
      for (int j = 0; j < TAG_GRP; j++) begin
        if (3'(j) < groups) begin
          tsh       = 5'(7 * (int'(groups) - 1 - j));
          tb[j + 1] = {(3'(j) < groups - 3'd1), 7'(tag >> tsh)};
        end
      end
      tn = 4'd1 + 4'(groups);
    end
  end

  always_comb begin
    lb  = '0;
    nb  = 3'd1;
    lsh = '0;
    if (len < 32'h80) begin
      lb[0] = len[7:0];
      ln    = 4'd1;
    end else begin
      if (len > 32'hff)     nb = 3'd2;
      if (len > 32'hffff)   nb = 3'd3;
      if (len > 32'hffffff) nb = 3'd4;
      lb[0] = LEN_LONG_BASE + 8'(nb);
      for (int j = 0; j < LEN_BYTES; j++) begin
        if (3'(j) < nb) begin
          lsh       = 5'(8 * (int'(nb) - 1 - j));
          lb[j + 1] = 8'(len >> lsh);
        end
      end
      ln = 4'd1 + 4'(nb);
    end
  end

  assign n = tn + ln;

  always_comb begin
    hdr = '0;
    rel = '0;
    priority if (!rule_is_der) begin
      hdr.count  = 4'd1;
      hdr.status = ST_BAD_RULE;
    end else if (!rule_desc.is_present || rule_desc.is_dummy ||
                 rule_desc.is_default_value) begin
      hdr.count  = 4'd1;
      hdr.status = rule_desc.is_default_value ? ST_DEFAULT : ST_ABSENT;
    end else if (&tag) begin
      hdr.count  = 4'd1;
      hdr.status = ST_TAG_BAD;
    end else if (len[31:30] != 2'b00) begin
      hdr.count  = 4'd1;
      hdr.status = ST_TOO_LONG;
    end else begin
      hdr.count       = n;
      hdr.header_size = n;
      hdr.status      = ST_OK;
      hdr.byte_valid  = 1'b1;
      for (int k = 0; k < HDR_MAX; k++) begin
        rel = 4'(k) - tn;
        if (4'(k) < tn) begin
          hdr.bytes[k] = tb[3'(k)];
        end else if (rel < ln) begin
          hdr.bytes[k] = lb[rel[2:0]];
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/dthe_ser.sv]
// Byte serializer: holds one built header and shifts it out a beat at a time.
// Acts as the result register of the encoder; uses dthe_pkg types.
`default_nettype none

module dthe_ser
  import dthe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       src_valid,
  output logic            src_ready,
  input  wire hdr_t       src_hdr,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            last,
  output logic [2:0]      status,
  output logic [3:0]      header_size
);

  logic                    busy_r,  busy_nxt;
  logic [3:0]              rem_r,   rem_nxt;
  logic [HDR_MAX-1:0][7:0] bytes_r, bytes_nxt;
  logic [2:0]              stat_r,  stat_nxt;
  logic [3:0]              size_r,  size_nxt;
  logic                    bv_r,    bv_nxt;
  logic                    take;
  logic                    fin;
  logic                    load;

  assign take      = busy_r && out_ready;
  assign fin       = take && (rem_r == 4'd1);
  assign src_ready = !busy_r || fin;
  assign load      = src_ready && src_valid;

  always_comb begin
    busy_nxt  = busy_r;
    rem_nxt   = rem_r;
    bytes_nxt = bytes_r;
    stat_nxt  = stat_r;
    size_nxt  = size_r;
    bv_nxt    = bv_r;
    priority if (load) begin
      busy_nxt  = 1'b1;
      rem_nxt   = src_hdr.count;
      bytes_nxt = src_hdr.bytes;
      stat_nxt  = src_hdr.status;
      size_nxt  = src_hdr.header_size;
      bv_nxt    = src_hdr.byte_valid;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end else if (take) begin
      rem_nxt   = rem_r - 4'd1;
      bytes_nxt = {8'h00, bytes_r[HDR_MAX-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
    end
    bytes_r <= bytes_nxt;
    stat_r  <= stat_nxt;
    size_r  <= size_nxt;
    bv_r    <= bv_nxt;
  end

  assign out_valid   = busy_r;
  assign out_byte    = bytes_r[0];
  assign byte_valid  = bv_r;
  assign last        = (rem_r == 4'd1);
  assign status      = stat_r;
  assign header_size = size_r;

endmodule

`default_nettype wire

[rtl/der_tag_length_header_encoder_core.sv]
// DER identifier and length octet encoder, top level.
// One descriptor in gives its header bytes out, one byte per beat. A header
// is 2 to 11 bytes long, and a rejected or omitted object gives a single
// beat; the serializer shifts one byte per cycle while out_tready is high.
// A new descriptor is taken while the previous header still drains.
// Depends on dthe_pkg, dthe_build and dthe_ser.
`default_nettype none

module der_tag_length_header_encoder_core
  import dthe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,       // rule_is_der
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,        // tag_number, class_bits, content_length, pad
  input  wire logic [2:0]  in_tuser,        // is_present, is_dummy, is_default_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,       // out_byte, header_size, pad
  output logic [3:0]       out_tuser,       // byte_valid, status
  output logic             out_tlast
);

  logic  rule_r;
  logic  in_v_r, in_v_nxt;
  desc_t desc_r, desc_nxt;
  desc_t in_desc;
  hdr_t  hdr;
  logic  ser_ready;
  logic  in_acc;
  logic [7:0] ob;
  logic       bv;
  logic [2:0] st;
  logic [3:0] hs;

  assign in_desc.tag_number       = in_tdata[31:0];
  assign in_desc.class_bits       = in_tdata[34:32];
  assign in_desc.content_length   = in_tdata[66:35];
  assign in_desc.is_present       = in_tuser[0];
  assign in_desc.is_dummy         = in_tuser[1];
  assign in_desc.is_default_value = in_tuser[2];

  assign in_tready = !in_v_r || ser_ready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_v_nxt = in_v_r;
    desc_nxt = desc_r;
    priority if (in_acc) begin
      in_v_nxt = 1'b1;
      desc_nxt = in_desc;
    end else if (ser_ready) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r <= 1'b1;
      in_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rule_r <= cfg_wdata;
      end
      in_v_r <= in_v_nxt;
    end
    desc_r <= desc_nxt;
  end

  dthe_build u_build (
    .rule_desc   (desc_r),
    .rule_is_der (rule_r),
    .hdr         (hdr)
  );

  dthe_ser u_ser (
    .clk         (clk),
    .rst_n       (rst_n),
    .src_valid   (in_v_r),
    .src_ready   (ser_ready),
    .src_hdr     (hdr),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (ob),
    .byte_valid  (bv),
    .last        (out_tlast),
    .status      (st),
    .header_size (hs)
  );

  assign out_tdata = {4'h0, hs, ob};
  assign out_tuser = {st, bv};

endmodule

`default_nettype wire
